// ===== rtl/sntp_pkg.sv =====
// Shared types and constants for the NTP server reply builder.
`timescale 1ns / 1ps

package sntp_pkg;

  // Reply framing
  localparam logic [5:0] REPLY_LEN      = 6'd48;
  localparam logic [5:0] REPLY_LAST_IDX = 6'd47;
  localparam logic [5:0] TS_FIRST_POS   = 6'd40;
  localparam logic [7:0] LI_VN_MODE     = 8'h24;

  // Time conversion: one million is 64 times 15625
  localparam logic [31:0] EPOCH_DELTA = 32'd2208988800;
  localparam logic [13:0] DIV_ODD     = 14'd15625;
  // ceil(2^44 / 15625), exact for every dividend below 2^30
  localparam logic [30:0] DIV_RECIP   = 31'd1125899907;
  // Rounding term of half a million, scaled down by 64
  localparam logic [15:0] FRAC_TAIL   = 16'd7812;
  localparam logic [3:0]  SECS_STEP   = 4'd7;
  localparam logic [3:0]  FRAC_STEP   = 4'd11;

  // Configuration register indexes
  localparam logic [2:0] REG_STRATUM    = 3'd0;
  localparam logic [2:0] REG_POLL       = 3'd1;
  localparam logic [2:0] REG_PRECISION  = 3'd2;
  localparam logic [2:0] REG_ROOT_DELAY = 3'd3;
  localparam logic [2:0] REG_ROOT_DISP  = 3'd4;
  localparam logic [2:0] REG_REF_ID     = 3'd5;

  // Configuration reset values
  localparam logic [7:0]  RST_STRATUM    = 8'd1;
  localparam logic [7:0]  RST_POLL       = 8'd6;
  localparam logic [7:0]  RST_PRECISION  = 8'hEC;
  localparam logic [31:0] RST_ROOT_DELAY = 32'h0001_0000;
  localparam logic [31:0] RST_ROOT_DISP  = 32'h0001_0000;
  localparam logic [31:0] RST_REF_ID     = 32'd1212629298;

  typedef struct packed {
    logic [7:0]  stratum;
    logic [7:0]  poll;
    logic [7:0]  precision;
    logic [31:0] root_delay;
    logic [31:0] root_disp;
    logic [31:0] ref_id;
  } cfg_t;

  // One accepted request waiting for its reply
  typedef struct packed {
    logic [63:0] client_ts;
    logic [63:0] now_us;
  } job_t;

  // Converted timestamps ready for serialization
  typedef struct packed {
    logic [63:0] client_ts;
    logic [31:0] ntp_secs;
    logic [31:0] frac_word;
  } time_result_t;

endpackage

// ===== rtl/sntp_front.sv =====
// Request byte counter and client timestamp capture.
`timescale 1ns / 1ps

module sntp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    payload_byte,
  input  logic          end_of_packet,
  input  logic [63:0]   now_microseconds,
  output logic          job_push,
  output sntp_pkg::job_t job
);
  import sntp_pkg::*;

  logic [5:0]  byte_position;
  logic [5:0]  byte_position_next;
  logic [63:0] client_timestamp;
  logic [63:0] client_timestamp_next;

  // Shift in request bytes 40 to 47 and saturate the count at the reply length
  always_comb begin
    client_timestamp_next = client_timestamp;
    byte_position_next    = byte_position;
    if (byte_position >= TS_FIRST_POS && byte_position < REPLY_LEN) begin
      client_timestamp_next = {client_timestamp[55:0], payload_byte};
    end
    if (byte_position < REPLY_LEN) begin
      byte_position_next = byte_position + 6'd1;
    end
  end

  // Hand a full-length request to the back end on its final byte
  assign job_push       = accept && end_of_packet && (byte_position_next == REPLY_LEN);
  assign job.client_ts  = client_timestamp_next;
  assign job.now_us     = now_microseconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= end_of_packet ? 6'd0 : byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      client_timestamp <= client_timestamp_next;
    end
  end

endmodule

// ===== rtl/sntp_job_queue.sv =====
// Short register queue between the request front end and the reply back end.
`timescale 1ns / 1ps

module sntp_job_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sntp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output sntp_pkg::job_t head_job
);
  import sntp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head_job  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/sntp_time_conv.sv =====
// Unix microseconds to NTP 32.32 conversion by reciprocal multiplication.
`timescale 1ns / 1ps

module sntp_time_conv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  sntp_pkg::job_t         job,
  output logic                   job_pop,
  output logic                   res_valid,
  output sntp_pkg::time_result_t res,
  input  logic                   res_take
);
  import sntp_pkg::*;

  logic        busy;
  logic        done;
  logic [3:0]  step_cnt;
  logic [95:0] feed;
  logic [13:0] rem;
  logic [29:0] part;
  logic [15:0] part_quot;
  logic [31:0] quot;
  logic [29:0] trial;
  logic [59:0] prod;
  logic [29:0] part_back;
  logic [29:0] part_rem;
  logic [31:0] quot_next;
  logic        in_ready;

  assign in_ready  = !busy && (!done || res_take);
  assign job_pop   = job_valid && in_ready;
  assign res_valid = done;

  // Long division by 15625 in 16-bit digits: estimate on even steps,
  // take the remainder on odd steps
  always_comb begin
    trial     = {rem, feed[95:80]};
    prod      = {30'd0, trial} * {29'd0, DIV_RECIP};
    part_back = {14'd0, part_quot} * {16'd0, DIV_ODD};
    part_rem  = part - part_back;
    quot_next = {quot[15:0], part_quot};
  end

  // Control: load, iterate 12 steps, hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      if (res_take) begin
        done <= 1'b0;
      end
      if (job_pop) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 4'd1;
        if (step_cnt == FRAC_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: four digits of us / 64 give the seconds, the remainder
  // continues through two more digits for the rounded fraction
  always_ff @(posedge clk) begin
    if (job_pop) begin
      feed          <= {6'd0, job.now_us, 10'd0, FRAC_TAIL};
      rem           <= '0;
      res.client_ts <= job.client_ts;
    end else if (busy) begin
      if (!step_cnt[0]) begin
        part      <= trial;
        part_quot <= prod[59:44];
      end else begin
        rem  <= part_rem[13:0];
        quot <= quot_next;
        feed <= {feed[79:0], 16'd0};
        if (step_cnt == SECS_STEP) begin
          res.ntp_secs <= quot_next + EPOCH_DELTA;
        end
        if (step_cnt == FRAC_STEP) begin
          res.frac_word <= quot_next;
        end
      end
    end
  end

endmodule

// ===== rtl/sntp_reply_stream.sv =====
// Reply serializer with its output register.
`timescale 1ns / 1ps

module sntp_reply_stream (
  input  logic                   clk,
  input  logic                   rst,
  input  sntp_pkg::cfg_t         cfg,
  input  logic                   res_valid,
  input  sntp_pkg::time_result_t res,
  output logic                   res_take,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             reply_byte,
  output logic                   reply_last
);
  import sntp_pkg::*;

  logic         active;
  logic [5:0]   idx;
  time_result_t rec;
  logic         out_valid;
  logic         advance;
  logic         at_last;
  logic [5:0]   sel;
  logic [383:0] frame;
  logic [7:0]   frame_byte;

  assign empty   = !out_valid;
  assign advance = active && (!out_valid || pop);
  assign at_last = (idx == REPLY_LAST_IDX);
  assign res_take = res_valid && (!active || (advance && at_last));

  // Lay out the 48-byte reply, byte 0 in the top bits
  assign frame = {LI_VN_MODE, cfg.stratum, cfg.poll, cfg.precision,
                  cfg.root_delay, cfg.root_disp, cfg.ref_id, 64'd0,
                  rec.client_ts, rec.ntp_secs, rec.frac_word,
                  rec.ntp_secs, rec.frac_word};
  assign sel        = REPLY_LAST_IDX - idx;
  assign frame_byte = frame[{sel, 3'b000} +: 8];

  // Walk the reply bytes, load the next record right behind the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_take) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (advance) begin
        if (at_last) begin
          active <= 1'b0;
        end
        idx <= idx + 6'd1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rec <= res;
    end
    if (advance) begin
      reply_byte <= frame_byte;
      reply_last <= at_last;
    end
  end

endmodule

// ===== rtl/ntp_server_reply_builder_unit.sv =====
// Top level of the NTP server reply builder.
`timescale 1ns / 1ps
//
// Request side: one payload byte per beat on push/full, with end_of_packet
// marking the final byte and now_microseconds sampled on that beat. Bytes are
// taken one per cycle while full is low; full rises only while the job queue
// holds JOB_QUEUE_DEPTH requests waiting for the back end.
// A request shorter than 48 bytes is dropped with no output.
// Reply side: a 48-beat burst on empty/pop, reply_last on the final beat.
// The time converter divides by one million with a reciprocal multiply,
// one 16-bit quotient digit per estimate step and remainder step. After
// the final request byte is accepted, the job passes through the queue,
// the converter and the serializer into the output register. Bytes then
// leave at one per cycle while pop is high, and the next request converts
// while the current reply drains, so 48-byte requests sustain one byte per cycle.
// A stalled pop holds the output register; the converter and queue fill up
// behind it and full then stalls the request side.
// Reset (rst, synchronous) empties the queue, clears the byte count and
// restores the configuration registers to their defaults.
// Configuration writes via cfg_write_enable/cfg_index/cfg_data take effect
// at the next edge and must only be made while the block is idle.

module ntp_server_reply_builder_unit #(
  parameter int JOB_QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  payload_byte,
  input  logic        end_of_packet,
  input  logic [63:0] now_microseconds,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  reply_byte,
  output logic        reply_last,
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sntp_pkg::*;

  cfg_t         cfg;
  logic         accept;
  logic         job_push;
  job_t         front_job;
  logic         queue_full;
  logic         queue_not_empty;
  job_t         head_job;
  logic         job_pop;
  logic         res_valid;
  time_result_t res;
  logic         res_take;

  assign full   = queue_full;
  assign accept = push && !queue_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stratum    <= RST_STRATUM;
      cfg.poll       <= RST_POLL;
      cfg.precision  <= RST_PRECISION;
      cfg.root_delay <= RST_ROOT_DELAY;
      cfg.root_disp  <= RST_ROOT_DISP;
      cfg.ref_id     <= RST_REF_ID;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_STRATUM:    cfg.stratum    <= cfg_data[7:0];
        REG_POLL:       cfg.poll       <= cfg_data[7:0];
        REG_PRECISION:  cfg.precision  <= cfg_data[7:0];
        REG_ROOT_DELAY: cfg.root_delay <= cfg_data;
        REG_ROOT_DISP:  cfg.root_disp  <= cfg_data;
        REG_REF_ID:     cfg.ref_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  sntp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .payload_byte     (payload_byte),
    .end_of_packet    (end_of_packet),
    .now_microseconds (now_microseconds),
    .job_push         (job_push),
    .job              (front_job)
  );

  sntp_job_queue #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (front_job),
    .full      (queue_full),
    .pop       (job_pop),
    .not_empty (queue_not_empty),
    .head_job  (head_job)
  );

  sntp_time_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_not_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  sntp_reply_stream u_stream (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .empty      (empty),
    .pop        (pop),
    .reply_byte (reply_byte),
    .reply_last (reply_last)
  );

endmodule
